[src/csca_pkg.sv]
package csca_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 128;

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);

	localparam int RCFG_W = 7;
	localparam int CCFG_W = 8;
	localparam int THR_W  = 4;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 2;
	localparam int DATA_W = 8;

	localparam logic [RCFG_W-1:0] ROWS_RST   = RCFG_W'(64);
	localparam logic [CCFG_W-1:0] COLS_RST   = CCFG_W'(128);
	localparam logic [THR_W-1:0]  THRESH_RST = THR_W'(4);

	typedef enum logic [IDX_W-1:0] {
		REG_ROWS   = 2'd0,
		REG_COLS   = 2'd1,
		REG_THRESH = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_READ  = 2'd1,
		REQ_PASS  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef struct packed {
		logic [RCFG_W-1:0] eff_rows;
		logic [CCFG_W-1:0] eff_cols;
		logic [THR_W-1:0]  threshold;
	} grid_cfg_t;

	// neighbor bits, index 0 is column c-1, index 2 is column c+1
	typedef struct packed {
		logic [2:0] up;
		logic       left;
		logic       right;
		logic [2:0] dn;
	} nbr_t;

	typedef struct packed {
		logic row_first;
		logic row_last;
		logic col_first;
		logic col_last;
	} bound_t;

	typedef struct packed {
		logic             re;
		logic [ROW_W-1:0] raddr;
		logic             we;
		logic [ROW_W-1:0] waddr;
	} ram_cmd_t;

endpackage

[src/csca_ram.sv]
module csca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/csca_eval.sv]
module csca_eval (
	input  csca_pkg::nbr_t                  nbr,
	input  csca_pkg::bound_t                bound,
	input  logic [csca_pkg::THR_W-1:0]      threshold,
	input  logic                            cur_bit,
	output logic                            new_bit
);

	import csca_pkg::*;

	nbr_t             masked;
	logic [CNT_W-1:0] count;

	// cells off the grid and row zero count as walls
	always_comb begin
		masked = nbr;
		if (bound.row_first) begin
			masked.up = 3'b111;
		end
		if (bound.row_last) begin
			masked.dn = 3'b111;
		end
		if (bound.col_first) begin
			masked.up[0] = 1'b1;
			masked.dn[0] = 1'b1;
			masked.left  = 1'b1;
		end
		if (bound.col_last) begin
			masked.up[2] = 1'b1;
			masked.dn[2] = 1'b1;
			masked.right = 1'b1;
		end
		count   = CNT_W'($countones(masked));
		new_bit = cur_bit | (count > threshold);
	end

endmodule

[src/csca_ctrl.sv]
module csca_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  csca_pkg::grid_cfg_t             cfg,
	input  logic                            start,
	input  logic [1:0]                      req_type,
	input  logic [csca_pkg::ROW_W-1:0]      cell_row,
	input  logic [csca_pkg::COL_W-1:0]      cell_col,
	input  logic                            wall_in,
	output logic                            busy,
	output logic                            done,
	output logic                            wall_out,
	output logic                            bad_address,
	output csca_pkg::ram_cmd_t              ram_cmd,
	output logic [csca_pkg::MAX_COLS-1:0]   ram_wdata,
	input  logic [csca_pkg::MAX_COLS-1:0]   ram_rdata,
	output csca_pkg::nbr_t                  nbr,
	output csca_pkg::bound_t                bound,
	output logic                            cur_bit,
	input  logic                            new_bit
);

	import csca_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CELL,
		ST_LOAD_CUR,
		ST_LOAD_NXT,
		ST_SWEEP,
		ST_WB
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic              wall_q;
	logic [ROW_W-1:0]  r_q;
	logic [COL_W-1:0]  c_q;
	logic [MAX_COLS-1:0] prev_q;
	logic [MAX_COLS-1:0] cur_q;
	logic [MAX_COLS-1:0] next_q;
	logic              done_q;
	logic              wall_out_q;
	logic              bad_q;

	req_t              req_in;
	logic              accept;
	logic              addr_bad;
	logic              grid_empty;
	logic [COL_W-1:0]  c_m1;
	logic [COL_W-1:0]  c_p1;

	assign req_in     = req_t'(req_type);
	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign wall_out   = wall_out_q;
	assign bad_address = bad_q;

	assign addr_bad   = (cell_row == '0) || (RCFG_W'(cell_row) >= cfg.eff_rows) ||
			(CCFG_W'(cell_col) >= cfg.eff_cols);
	assign grid_empty = (cfg.eff_rows < RCFG_W'(2)) || (cfg.eff_cols == '0);

	assign c_m1 = c_q - COL_W'(1);
	assign c_p1 = c_q + COL_W'(1);

	always_comb begin
		nbr.up          = {prev_q[c_p1], prev_q[c_q], prev_q[c_m1]};
		nbr.left        = cur_q[c_m1];
		nbr.right       = cur_q[c_p1];
		nbr.dn          = {next_q[c_p1], next_q[c_q], next_q[c_m1]};
		bound.row_first = (r_q == ROW_W'(1));
		bound.row_last  = (RCFG_W'(r_q) + RCFG_W'(1) >= cfg.eff_rows);
		bound.col_first = (c_q == '0);
		bound.col_last  = (CCFG_W'(c_q) + CCFG_W'(1) >= cfg.eff_cols);
		cur_bit         = cur_q[c_q];
	end

	// memory port
	always_comb begin
		ram_cmd   = '0;
		ram_wdata = cur_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_cmd.re    = start;
				ram_cmd.raddr = (req_in == REQ_PASS) ? ROW_W'(1) : cell_row;
			end
			ST_CELL: begin
				ram_wdata        = ram_rdata;
				ram_wdata[col_q] = wall_q;
				ram_cmd.we       = (req_q == REQ_WRITE);
				ram_cmd.waddr    = row_q;
			end
			ST_LOAD_CUR: begin
				ram_cmd.re    = 1'b1;
				ram_cmd.raddr = r_q + ROW_W'(1);
			end
			ST_LOAD_NXT, ST_SWEEP: begin
			end
			ST_WB: begin
				ram_cmd.we    = 1'b1;
				ram_cmd.waddr = r_q;
				ram_cmd.re    = 1'b1;
				ram_cmd.raddr = r_q + ROW_W'(2);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			wall_out_q <= 1'b0;
			bad_q      <= 1'b0;
			req_q      <= REQ_NONE;
			row_q      <= '0;
			col_q      <= '0;
			wall_q     <= 1'b0;
			r_q        <= '0;
			c_q        <= '0;
			prev_q     <= '0;
			cur_q      <= '0;
			next_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q  <= req_in;
						row_q  <= cell_row;
						col_q  <= cell_col;
						wall_q <= wall_in;
						wall_out_q <= 1'b0;
						bad_q      <= 1'b0;
						unique case (req_in)
							REQ_WRITE, REQ_READ: begin
								if (addr_bad) begin
									bad_q  <= 1'b1;
									done_q <= 1'b1;
								end else begin
									state_q <= ST_CELL;
								end
							end
							REQ_PASS: begin
								if (grid_empty) begin
									done_q <= 1'b1;
								end else begin
									r_q     <= ROW_W'(1);
									state_q <= ST_LOAD_CUR;
								end
							end
							REQ_NONE: begin
								done_q <= 1'b1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CELL: begin
					wall_out_q <= (req_q == REQ_READ) ? ram_rdata[col_q] : 1'b0;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_LOAD_CUR: begin
					cur_q   <= ram_rdata;
					state_q <= ST_LOAD_NXT;
				end
				ST_LOAD_NXT: begin
					next_q  <= ram_rdata;
					c_q     <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					cur_q[c_q] <= new_bit;
					if (bound.col_last) begin
						state_q <= ST_WB;
					end else begin
						c_q <= c_p1;
					end
				end
				ST_WB: begin
					prev_q <= cur_q;
					cur_q  <= next_q;
					if (bound.row_last) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						r_q     <= r_q + ROW_W'(1);
						state_q <= ST_LOAD_NXT;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[src/cave_smoothing_cellular_automaton_top.sv]
// Cave smoothing cellular automaton: a one-bit wall/floor grid held in a
// row-wide memory, one row of cells per word.
// Request channel: an item is taken when start is high and busy is low.
// req_type selects a cell write, a cell read, or one smoothing pass; cell_row
// and cell_col address the cell, wall_in is the value written.
// Result channel: done pulses for one cycle with wall_out and bad_address;
// every request gives exactly one result and the receiver cannot stall it.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write only while busy is low and no result is pending.
// A bad address, an unused request or a pass on a grid of under two rows or
// no columns answers in the cycle after accept; a valid read or write first
// reads the row, then writes it back (writes only) and registers the result.
// A pass works row by row: one memory read, one cell per cycle through the
// neighbour counter, then one row write beside the read of a later row.
// Reset clears control state and loads the config registers with their
// defaults; grid contents are undefined until written.
module cave_smoothing_cellular_automaton_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      req_type,
	input  logic [csca_pkg::ROW_W-1:0]      cell_row,
	input  logic [csca_pkg::COL_W-1:0]      cell_col,
	input  logic                            wall_in,
	output logic                            done,
	output logic                            wall_out,
	output logic                            bad_address,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [csca_pkg::IDX_W-1:0]      cfg_index,
	input  logic [csca_pkg::DATA_W-1:0]     cfg_data
);

	import csca_pkg::*;

	logic [RCFG_W-1:0]   rows_q;
	logic [CCFG_W-1:0]   cols_q;
	logic [THR_W-1:0]    thresh_q;
	grid_cfg_t           cfg;
	ram_cmd_t            ram_cmd;
	logic [MAX_COLS-1:0] ram_wdata;
	logic [MAX_COLS-1:0] ram_rdata;
	nbr_t                nbr;
	bound_t              bound;
	logic                cur_bit;
	logic                new_bit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			thresh_q <= THRESH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROWS:   rows_q   <= cfg_data[RCFG_W-1:0];
				REG_COLS:   cols_q   <= cfg_data[CCFG_W-1:0];
				REG_THRESH: thresh_q <= cfg_data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.eff_rows  = (int'(rows_q) > MAX_ROWS) ? RCFG_W'(MAX_ROWS) : rows_q;
		cfg.eff_cols  = (int'(cols_q) > MAX_COLS) ? CCFG_W'(MAX_COLS) : cols_q;
		cfg.threshold = thresh_q;
	end

	csca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.start       (start),
		.req_type    (req_type),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.wall_in     (wall_in),
		.busy        (busy),
		.done        (done),
		.wall_out    (wall_out),
		.bad_address (bad_address),
		.ram_cmd     (ram_cmd),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.nbr         (nbr),
		.bound       (bound),
		.cur_bit     (cur_bit),
		.new_bit     (new_bit)
	);

	csca_eval u_eval (
		.nbr       (nbr),
		.bound     (bound),
		.threshold (cfg.threshold),
		.cur_bit   (cur_bit),
		.new_bit   (new_bit)
	);

	csca_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_ram (
		.clk   (clk),
		.we    (ram_cmd.we),
		.waddr (ram_cmd.waddr),
		.wdata (ram_wdata),
		.re    (ram_cmd.re),
		.raddr (ram_cmd.raddr),
		.rdata (ram_rdata)
	);

	// a result always closes the transaction
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted transaction dropped");

	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(wall_out && bad_address))
		else $error("read data on bad address");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_cmd.we && ram_cmd.re) |-> (ram_cmd.waddr != ram_cmd.raddr))
		else $error("memory read and write to same row");

endmodule

[tb/tb_cave_smoothing_cellular_automaton_top.sv]
module tb_cave_smoothing_cellular_automaton_top;
	timeunit 1ns;
	timeprecision 1ps;

	import csca_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int TAIL_CYCLES = 16;
	localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic wall;
		logic bad;
	} cell_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	req_t              req_type = REQ_NONE;
	logic [ROW_W-1:0]  cell_row = '0;
	logic [COL_W-1:0]  cell_col = '0;
	logic              wall_in = 1'b0;
	logic              done;
	logic              wall_out;
	logic              bad_address;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	bit                cave_map [MAX_ROWS][MAX_COLS];
	bit                cave_known [MAX_ROWS][MAX_COLS];
	logic [RCFG_W-1:0] rows_reg = ROWS_RST;
	logic [CCFG_W-1:0] cols_reg = COLS_RST;
	logic [THR_W-1:0]  thresh_reg = THRESH_RST;
	cell_result_t      results_due [$];
	int                mismatches = 0;
	int                cycle_count = 0;
	bit                gaps_on = 1'b1;

	cave_smoothing_cellular_automaton_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int live_rows();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic int live_cols();
		return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	function automatic bit in_cave(int r, int c);
		return r >= 1 && r < live_rows() && c >= 0 && c < live_cols();
	endfunction

	function automatic bit cave_ready();
		for (int r = 1; r < live_rows(); r++)
			for (int c = 0; c < live_cols(); c++)
				if (!cave_known[r][c])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic int wall_neighbors(int r, int c);
		int n = 0;
		for (int dr = -1; dr <= 1; dr++)
			for (int dc = -1; dc <= 1; dc++) begin
				if (dr == 0 && dc == 0)
					continue;
				if (!in_cave(r + dr, c + dc))
					n++;
				else if (cave_map[r + dr][c + dc])
					n++;
			end
		return n;
	endfunction

	// in-place raster sweep, earlier cells feed later counts
	function automatic void smooth_cave();
		for (int r = 1; r < live_rows(); r++)
			for (int c = 0; c < live_cols(); c++)
				if (wall_neighbors(r, c) > int'(thresh_reg))
					cave_map[r][c] = 1'b1;
	endfunction

	function automatic cell_result_t predict_cell(req_t kind, int r, int c, bit w);
		cell_result_t res = '0;
		case (kind)
			REQ_WRITE, REQ_READ: begin
				if (!in_cave(r, c)) begin
					res.bad = 1'b1;
				end else if (kind == REQ_WRITE) begin
					cave_map[r][c] = w;
					cave_known[r][c] = 1'b1;
				end else begin
					res.wall = cave_map[r][c];
				end
			end
			REQ_PASS: begin
				smooth_cave();
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic send_req(req_t kind, int r, int c, bit w);
		while (gaps_on && $urandom_range(99) < 22) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		cell_row <= r[ROW_W-1:0];
		cell_col <= c[COL_W-1:0];
		wall_in <= w;
		do @(posedge clk); while (busy !== 1'b0);
		results_due.push_back(predict_cell(kind, r, c, w));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_ROWS:   rows_reg = val[RCFG_W-1:0];
			REG_COLS:   cols_reg = val[CCFG_W-1:0];
			REG_THRESH: thresh_reg = val[THR_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic configure(int rows, int cols, int thr);
		write_reg(REG_ROWS, DATA_W'(rows));
		write_reg(REG_COLS, DATA_W'(cols));
		write_reg(REG_THRESH, DATA_W'(thr));
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_cave(int density);
		for (int r = 1; r < live_rows(); r++)
			for (int c = 0; c < live_cols(); c++)
				send_req(REQ_WRITE, r, c, $urandom_range(99) < density);
	endtask

	task automatic send_bad(req_t kind);
		int r;
		int c;
		do begin
			r = ($urandom_range(1) == 0) ? 0 : $urandom_range(MAX_ROWS - 1);
			c = $urandom_range(MAX_COLS - 1);
		end while (in_cave(r, c));
		send_req(kind, r, c, $urandom_range(1));
	endtask

	task automatic send_cell(req_t kind);
		int r;
		int c;
		r = $urandom_range(live_rows() - 1, 1);
		c = $urandom_range(live_cols() - 1, 0);
		// never read a cell that was not written yet
		if (kind == REQ_READ && !cave_known[r][c])
			kind = REQ_WRITE;
		send_req(kind, r, c, $urandom_range(1));
	endtask

	task automatic random_op();
		int pick = $urandom_range(99);
		if (pick < 30)
			send_cell(REQ_WRITE);
		else if (pick < 55)
			send_cell(REQ_READ);
		else if (pick < 70 && cave_ready())
			send_req(REQ_PASS, $urandom_range(63), $urandom_range(127), $urandom_range(1));
		else if (pick < 90)
			send_bad(pick[0] ? REQ_READ : REQ_WRITE);
		else
			send_req(REQ_NONE, $urandom_range(63), $urandom_range(127), $urandom_range(1));
	endtask

	task automatic test_default_grid();
		send_req(REQ_WRITE, 1, 0, 1'b1);
		send_req(REQ_READ, 1, 0, 1'b0);
		send_req(REQ_WRITE, MAX_ROWS - 1, MAX_COLS - 1, 1'b1);
		send_req(REQ_READ, MAX_ROWS - 1, MAX_COLS - 1, 1'b0);
		send_req(REQ_WRITE, MAX_ROWS - 1, MAX_COLS - 1, 1'b0);
		send_req(REQ_READ, MAX_ROWS - 1, MAX_COLS - 1, 1'b1);
		send_req(REQ_WRITE, 0, MAX_COLS - 1, 1'b1);
		send_req(REQ_READ, 0, 0, 1'b0);
		send_req(REQ_NONE, MAX_ROWS - 1, MAX_COLS - 1, 1'b1);
		send_req(REQ_NONE, 0, 0, 1'b0);
		drain();
	endtask

	task automatic test_register_extremes();
		// oversized rows act as the full row count
		configure(127, 1, 0);
		send_req(REQ_WRITE, MAX_ROWS - 1, 0, 1'b1);
		send_req(REQ_READ, MAX_ROWS - 1, 0, 1'b0);
		send_req(REQ_READ, MAX_ROWS - 1, 1, 1'b0);
		drain();
		// oversized columns act as the full column count
		configure(2, 255, 8);
		send_req(REQ_WRITE, 1, MAX_COLS - 1, 1'b1);
		send_req(REQ_READ, 1, MAX_COLS - 1, 1'b0);
		send_req(REQ_READ, 2, 0, 1'b0);
		drain();
		// zero threshold: pass turns every floor to wall
		configure(3, 2, 0);
		fill_cave(0);
		send_req(REQ_PASS, 0, 0, 1'b0);
		send_req(REQ_READ, 1, 0, 1'b0);
		send_req(REQ_READ, 2, 1, 1'b0);
		drain();
		// threshold 8 and above never makes a wall
		configure(3, 2, 8);
		fill_cave(50);
		send_req(REQ_PASS, MAX_ROWS - 1, MAX_COLS - 1, 1'b1);
		send_req(REQ_READ, 1, 1, 1'b0);
		drain();
		configure(3, 2, 15);
		fill_cave(0);
		send_req(REQ_PASS, 0, 0, 1'b0);
		send_req(REQ_READ, 2, 0, 1'b0);
		drain();
		// write to the unused register index must not touch the grid size
		write_reg(REG_ROWS, DATA_W'(3));
		write_reg(REG_UNUSED, 8'hFF);
		write_reg(REG_COLS, DATA_W'(3));
		write_reg(REG_THRESH, DATA_W'(3));
		cfg_valid <= 1'b0;
		fill_cave(40);
		send_req(REQ_READ, 2, 2, 1'b0);
		send_req(REQ_READ, 3, 0, 1'b0);
		send_req(REQ_READ, 1, 3, 1'b0);
		send_req(REQ_PASS, 0, 0, 1'b0);
		send_req(REQ_READ, 1, 1, 1'b0);
		send_req(REQ_READ, 2, 0, 1'b0);
		drain();
	endtask

	task automatic test_degenerate_grid();
		configure(0, 16, 4);
		send_req(REQ_WRITE, 1, 0, 1'b1);
		send_req(REQ_PASS, 0, 0, 1'b0);
		drain();
		configure(1, 16, 4);
		send_req(REQ_READ, 1, 1, 1'b0);
		send_req(REQ_PASS, 0, 0, 1'b0);
		drain();
		configure(8, 0, 4);
		send_req(REQ_WRITE, 2, 0, 1'b1);
		send_req(REQ_READ, 1, 0, 1'b0);
		send_req(REQ_PASS, 0, 0, 1'b0);
		drain();
	endtask

	task automatic test_random_rounds();
		int rows;
		int cols;
		int thr;
		for (int round = 0; round < 4; round++) begin
			if (round == 1) begin
				rows = 4;
				cols = 4;
			end else begin
				rows = $urandom_range(2, 4);
				cols = $urandom_range(1, 4);
			end
			thr = ($urandom_range(4) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
			gaps_on = (round != 1);
			configure(rows, cols, thr);
			repeat (2) random_op();
			fill_cave($urandom_range(10, 70));
			repeat (6) random_op();
			drain();
		end
		gaps_on = 1'b1;
	endtask

	// result transaction check, one per done strobe
	always @(posedge clk) begin : check_results
		cell_result_t due;
		if (arst_n && done === 1'b1) begin
			if (results_due.size() == 0) begin
				$error("unexpected result transaction: wall_out=%0b bad_address=%0b",
					wall_out, bad_address);
				mismatches++;
			end else begin
				due = results_due.pop_front();
				if (wall_out !== due.wall) begin
					$error("wall_out: expected %0b actual %0b", due.wall, wall_out);
					mismatches++;
				end
				if (bad_address !== due.bad) begin
					$error("bad_address: expected %0b actual %0b", due.bad, bad_address);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_grid();
		test_register_extremes();
		test_degenerate_grid();
		test_random_rounds();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
